// File: rtl/coulomb_force_pair_assert.svh
// ---------------------------------------------------------------------------
// Coulomb pair force assertion macros
// Implication checks sampled on clk, held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COULOMB_FORCE_PAIR_ASSERT_SVH
`define COULOMB_FORCE_PAIR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CFP_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |-> (cons)) else $error("cfp same-cycle check failed");
// next-cycle implication
`define CFP_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("cfp next-cycle check failed");
`else
`define CFP_ASSERT_IMP(lbl, ante, cons)
`define CFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/cfp_pkg.sv
// ---------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the Coulomb pair force pipeline.
// ---------------------------------------------------------------------------
package cfp_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_POS_X  = 3'd0,
    CFG_POS_Y  = 3'd1,
    CFG_POS_Z  = 3'd2,
    CFG_CHARGE = 3'd3,
    CFG_SCALE  = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] OWN_CHARGE_RST = 16'hFE00;  // -2.0 in Q8.8
  localparam logic [31:0] SCALE_RST      = 32'h0001_0000;  // 1.0 in Q16.16

  localparam int ROOT_STEPS = 32;  // square root and force division steps
  localparam int UNIT_STEPS = 31;  // unit vector division steps

  typedef struct packed {
    logic signed [31:0] charge_x;
    logic signed [31:0] charge_y;
    logic signed [31:0] charge_z;
    logic signed [15:0] charge_q;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               zero_distance;
    logic               saturated;
  } out_word_t;

  // Per-item sideband carried along the long stages
  typedef struct packed {
    logic [2:0]        neg;
    logic              qneg;
    logic              zero;
    logic signed [5:0] sh;
    logic [2:0][29:0]  e;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [61:0] r2;
    logic [61:0] p;
  } front_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] d;
    logic [31:0] a;
  } root_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic              qneg;
    logic              zero;
    logic signed [5:0] sh;
    logic [31:0]       a;
    logic [2:0][30:0]  u;
  } scale_in_t;

endpackage

// File: rtl/cfp_stream_if.sv
// ---------------------------------------------------------------------------
// cfp_stream_if
// Valid/ready channel carrying one word of a given type.
// ---------------------------------------------------------------------------
interface cfp_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cfp_front.sv
// ---------------------------------------------------------------------------
// cfp_front
// Five stages: differences, normalising shift and charge product,
// normalised magnitudes, squares, squared distance.
// ---------------------------------------------------------------------------
module cfp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_v,
  input  cfp_pkg::in_word_t       in_d,
  input  logic [2:0][31:0]        own_pos,
  input  logic signed [15:0]      own_q,
  input  logic [31:0]             scale,
  output logic                    out_v,
  output cfp_pkg::front_t         out_d
);
  import cfp_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0][32:0]   mag1_r, mag1_nxt, mag2_r;
  logic [2:0]         neg1_r, neg1_nxt, neg2_r;
  logic signed [31:0] qq1_r, qq1_nxt;
  logic               qneg2_r, qneg2_nxt, zero2_r, zero2_nxt;
  logic signed [5:0]  sh2_r, sh2_nxt;
  logic [61:0]        p2_r, p2_nxt, p3_r, p4_r;
  side_t              side3_r, side3_nxt, side4_r;
  logic [2:0][59:0]   sq4_r, sq4_nxt;
  front_t             fr5_r, fr5_nxt;

  logic signed [31:0] pos [3];
  logic signed [32:0] dif [3];
  logic [32:0]        orm;
  logic [5:0]         bl;
  logic signed [6:0]  sh_w;
  logic [30:0]        qabs;
  logic [62:0]        pw;
  logic [5:0]         lsh;

  // Stage 1: exact differences and charge product
  always_comb begin
    pos[0] = in_d.charge_x;
    pos[1] = in_d.charge_y;
    pos[2] = in_d.charge_z;
    for (int i = 0; i < 3; i++) begin
      dif[i]      = 33'(pos[i]) - 33'(signed'(own_pos[i]));
      neg1_nxt[i] = dif[i][32];
      mag1_nxt[i] = dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
    end
    qq1_nxt = in_d.charge_q * own_q;
  end

  // Stage 2: common shift from the leading one, scaled charge product
  always_comb begin
    orm = mag1_r[0] | mag1_r[1] | mag1_r[2];
    bl  = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (orm[i]) bl = 6'(i + 1);
    end
    sh_w      = $signed({1'b0, bl}) - 7'sd30;
    sh2_nxt   = sh_w[5:0];
    zero2_nxt = (orm == 33'd0);
    qneg2_nxt = qq1_r[31];
    qabs      = qq1_r[31] ? 31'(-qq1_r) : 31'(qq1_r);
    pw        = scale * qabs;
    p2_nxt    = pw[61:0];
  end

  // Stage 3: normalise so the largest magnitude has 30 bits
  always_comb begin
    lsh            = 6'(-sh2_r);
    side3_nxt.neg  = neg2_r;
    side3_nxt.qneg = qneg2_r;
    side3_nxt.zero = zero2_r;
    side3_nxt.sh   = sh2_r;
    for (int i = 0; i < 3; i++) begin
      side3_nxt.e[i] = sh2_r[5] ? 30'(mag2_r[i] << lsh) : 30'(mag2_r[i] >> sh2_r[1:0]);
    end
  end

  // Stage 4: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_nxt[i] = side3_r.e[i] * side3_r.e[i];
    end
  end

  // Stage 5: squared distance
  always_comb begin
    fr5_nxt.side = side4_r;
    fr5_nxt.p    = p4_r;
    fr5_nxt.r2   = 62'(sq4_r[0]) + 62'(sq4_r[1]) + 62'(sq4_r[2]);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      qq1_r   <= qq1_nxt;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      qneg2_r <= qneg2_nxt;
      zero2_r <= zero2_nxt;
      sh2_r   <= sh2_nxt;
      p2_r    <= p2_nxt;
      side3_r <= side3_nxt;
      p3_r    <= p2_r;
      side4_r <= side3_r;
      sq4_r   <= sq4_nxt;
      p4_r    <= p3_r;
      fr5_r   <= fr5_nxt;
    end
  end

  assign out_v = v5_r;
  assign out_d = fr5_r;

endmodule

// File: rtl/cfp_root.sv
// ---------------------------------------------------------------------------
// cfp_root
// One square root digit and one force quotient bit per stage:
// D = floor(sqrt(R)) and A = floor(P * 2^28 / R).
// ---------------------------------------------------------------------------
module cfp_root (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_v,
  input  cfp_pkg::front_t  in_d,
  output logic             out_v,
  output cfp_pkg::root_t   out_d
);
  import cfp_pkg::*;

  typedef struct packed {
    side_t       side;
    logic [61:0] rr;
    logic [3:0]  p_lo;
    logic [63:0] x;
    logic [63:0] res;
    logic [61:0] rem;
    logic [31:0] q;
  } root_st_t;

  root_st_t init;
  root_st_t st_r [ROOT_STEPS];
  logic     v_r  [ROOT_STEPS];

  // Load the first step
  always_comb begin
    init.side = in_d.side;
    init.rr   = in_d.r2;
    init.p_lo = in_d.p[3:0];
    init.x    = 64'(in_d.r2);
    init.res  = 64'd0;
    init.rem  = 62'(in_d.p[61:4]);
    init.q    = 32'd0;
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT_VAL = 64'd1 << (62 - 2 * k);
    root_st_t prv, nxt;
    logic     pv, nb;

    if (k == 0) begin : g_first
      assign prv = init;
      assign pv  = in_v;
    end else begin : g_rest
      assign prv = st_r[k-1];
      assign pv  = v_r[k-1];
    end

    // Next numerator bit: only the top four come from P
    if (k < 4) begin : g_nb
      assign nb = prv.p_lo[3-k];
    end else begin : g_nb0
      assign nb = 1'b0;
    end

    // One root digit and one quotient bit
    always_comb begin
      logic [63:0] tb;
      logic [62:0] r;
      logic        qb;
      nxt = prv;
      tb  = prv.res + BIT_VAL;
      if (prv.x >= tb) begin
        nxt.x   = prv.x - tb;
        nxt.res = (prv.res >> 1) + BIT_VAL;
      end else begin
        nxt.res = prv.res >> 1;
      end
      r  = {prv.rem, nb};
      qb = 1'b0;
      if (r >= {1'b0, prv.rr}) begin
        r  = r - {1'b0, prv.rr};
        qb = 1'b1;
      end
      nxt.rem = r[61:0];
      nxt.q   = {prv.q[30:0], qb};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign out_v      = v_r[ROOT_STEPS-1];
  assign out_d.side = st_r[ROOT_STEPS-1].side;
  assign out_d.d    = st_r[ROOT_STEPS-1].res[30:0];
  assign out_d.a    = st_r[ROOT_STEPS-1].q;

endmodule

// File: rtl/cfp_unit.sv
// ---------------------------------------------------------------------------
// cfp_unit
// Unit vector in Q1.30: u_i = floor(e_i * 2^30 / D), one quotient bit of
// all three components per stage.
// ---------------------------------------------------------------------------
module cfp_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_v,
  input  cfp_pkg::root_t     in_d,
  output logic               out_v,
  output cfp_pkg::scale_in_t out_d
);
  import cfp_pkg::*;

  typedef struct packed {
    side_t            side;
    logic [31:0]      a;
    logic [30:0]      d;
    logic [2:0][30:0] rem;
    logic [2:0][30:0] u;
  } unit_st_t;

  unit_st_t init;
  unit_st_t st_r [UNIT_STEPS];
  logic     v_r  [UNIT_STEPS];

  // Load the first step: partial remainder is the numerator's top bits
  always_comb begin
    init.side = in_d.side;
    init.a    = in_d.a;
    init.d    = in_d.d;
    for (int i = 0; i < 3; i++) begin
      init.rem[i] = 31'(in_d.side.e[i][29:1]);
      init.u[i]   = 31'd0;
    end
  end

  for (genvar k = 0; k < UNIT_STEPS; k++) begin : g_step
    unit_st_t prv, nxt;
    logic     pv;

    if (k == 0) begin : g_first
      assign prv = init;
      assign pv  = in_v;
    end else begin : g_rest
      assign prv = st_r[k-1];
      assign pv  = v_r[k-1];
    end

    // One quotient bit per component
    always_comb begin
      logic [31:0] r;
      logic        qb;
      nxt = prv;
      for (int i = 0; i < 3; i++) begin
        r  = {prv.rem[i], ((k == 0) ? prv.side.e[i][0] : 1'b0)};
        qb = 1'b0;
        if (r >= {1'b0, prv.d}) begin
          r  = r - {1'b0, prv.d};
          qb = 1'b1;
        end
        nxt.rem[i] = r[30:0];
        nxt.u[i]   = {prv.u[i][29:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign out_v      = v_r[UNIT_STEPS-1];
  assign out_d.neg  = st_r[UNIT_STEPS-1].side.neg;
  assign out_d.qneg = st_r[UNIT_STEPS-1].side.qneg;
  assign out_d.zero = st_r[UNIT_STEPS-1].side.zero;
  assign out_d.sh   = st_r[UNIT_STEPS-1].side.sh;
  assign out_d.a    = st_r[UNIT_STEPS-1].a;
  assign out_d.u    = st_r[UNIT_STEPS-1].u;

endmodule

// File: rtl/cfp_scale.sv
// ---------------------------------------------------------------------------
// cfp_scale
// Registered products A * u_i, then rescale, saturate and apply the sign.
// ---------------------------------------------------------------------------
module cfp_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_v,
  input  cfp_pkg::scale_in_t in_d,
  output logic               out_v,
  output cfp_pkg::out_word_t out_d
);
  import cfp_pkg::*;

  logic              v_r;
  logic [2:0][62:0]  prod_r, prod_nxt;
  logic [2:0]        neg_r;
  logic              qneg_r, zero_r;
  logic signed [5:0] sh_r;

  logic signed [7:0] sh8, ex;
  logic [4:0]        nl;
  logic [31:0]       limit, lim_sh, fm;
  logic [62:0]       fw;
  logic              flip, over, sat;
  logic [31:0]       frc [3];

  // Force magnitudes before scaling
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = in_d.a * in_d.u[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      neg_r  <= in_d.neg;
      qneg_r <= in_d.qneg;
      zero_r <= in_d.zero;
      sh_r   <= in_d.sh;
    end
  end

  // Rescale by 2^-(2*sh+42), clip to Q16.16 and sign; a zero distance gives zero force
  always_comb begin
    sh8 = 8'(sh_r);
    ex  = (sh8 <<< 1) + 8'sd42;
    nl  = 5'(-ex);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      flip   = neg_r[i] ^ qneg_r;
      limit  = flip ? 32'h8000_0000 : 32'h7FFF_FFFF;
      lim_sh = limit >> nl;
      fw     = prod_r[i] >> ex[5:0];
      if (!ex[7]) begin
        over = (fw > 63'(limit));
        fm   = over ? limit : fw[31:0];
      end else begin
        over = (prod_r[i] > 63'(lim_sh));
        fm   = over ? limit : 32'(prod_r[i] << nl);
      end
      sat    = sat | over;
      frc[i] = flip ? (~fm + 32'd1) : fm;
    end
    if (zero_r) begin
      out_d.force_x       = 32'sd0;
      out_d.force_y       = 32'sd0;
      out_d.force_z       = 32'sd0;
      out_d.zero_distance = 1'b1;
      out_d.saturated     = 1'b0;
    end else begin
      out_d.force_x       = frc[0];
      out_d.force_y       = frc[1];
      out_d.force_z       = frc[2];
      out_d.zero_distance = 1'b0;
      out_d.saturated     = sat;
    end
  end

  assign out_v = v_r;

endmodule

// File: rtl/coulomb_force_pair.sv
// Throughput: one word per cycle while the skid register is empty; the
// pipeline takes one square root digit and one quotient bit per stage, so
// an item enters every cycle while nothing stalls. A result held at the
// output parks in a skid register; in_ch.ready then drops.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: position 0, charge -2.0, scale 1.0.
// ---------------------------------------------------------------------------
// coulomb_force_pair
// Pairwise Coulomb force between a stored element and a streamed charge.
// ---------------------------------------------------------------------------
`include "coulomb_force_pair_assert.svh"

module coulomb_force_pair (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata,
  cfp_stream_if.sink   in_ch,
  cfp_stream_if.source out_ch
);
  import cfp_pkg::*;

  logic [2:0][31:0]   own_pos_r;
  logic signed [15:0] own_q_r;
  logic [31:0]        scale_r;

  logic      adv;
  in_word_t  in_w;
  logic      fr_v, rt_v, un_v, sc_v;
  front_t    fr_d;
  root_t     rt_d;
  scale_in_t un_d;
  out_word_t sc_d;

  logic      out_v_r, skid_v_r;
  out_word_t out_d_r, skid_d_r;
  logic      out_clean;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_pos_r <= '0;
      own_q_r   <= OWN_CHARGE_RST;
      scale_r   <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_POS_X:  own_pos_r[0] <= cfg_wdata;
        CFG_POS_Y:  own_pos_r[1] <= cfg_wdata;
        CFG_POS_Z:  own_pos_r[2] <= cfg_wdata;
        CFG_CHARGE: own_q_r      <= cfg_wdata[15:0];
        CFG_SCALE:  scale_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline moves while the skid register is empty
  assign adv         = !skid_v_r;
  assign in_ch.ready = !skid_v_r;
  assign in_w        = in_ch.data;

  cfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_ch.valid),
    .in_d    (in_w),
    .own_pos (own_pos_r),
    .own_q   (own_q_r),
    .scale   (scale_r),
    .out_v   (fr_v),
    .out_d   (fr_d)
  );

  cfp_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (fr_v),
    .in_d  (fr_d),
    .out_v (rt_v),
    .out_d (rt_d)
  );

  cfp_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (rt_v),
    .in_d  (rt_d),
    .out_v (un_v),
    .out_d (un_d)
  );

  cfp_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .in_v  (un_v),
    .in_d  (un_d),
    .out_v (sc_v),
    .out_d (sc_d)
  );

  // Output register with skid: drain the skid first, park a word when stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= sc_v;
    end else if (sc_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ch.ready) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || out_ch.ready) begin
      out_d_r <= sc_d;
    end else begin
      skid_d_r <= sc_d;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  // A coincident word carries no force and no clip flag
  assign out_clean = (out_d_r.force_x == 32'sd0) && (out_d_r.force_y == 32'sd0) &&
                     (out_d_r.force_z == 32'sd0) && !out_d_r.saturated;

  `CFP_ASSERT_IMP(a_skid_has_out, skid_v_r, out_v_r)
  `CFP_ASSERT_NXT(a_skid_drains, skid_v_r && out_ch.ready, !skid_v_r && out_v_r)
  `CFP_ASSERT_IMP(a_zero_clean, out_v_r && out_d_r.zero_distance, out_clean)

endmodule

// File: dv/cfp_force_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfp_force_checker
// Watches the configuration port and both channels of the Coulomb pair
// force block, predicts each result word and compares it field by field.
// ---------------------------------------------------------------------------
module cfp_force_checker
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  output int          pending,
  output int          errors
);

  logic signed [31:0] own_pos [3];
  logic signed [15:0] own_q;
  logic        [31:0] k_scale;
  out_word_t          force_queue [$];

  // floor square root by digit recurrence
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // expected force word for one charge against the stored element
  function automatic out_word_t pair_force(in_word_t w);
    out_word_t       f;
    longint          diff;
    longint unsigned mag [3];
    longint unsigned e [3];
    logic [2:0]      neg;
    longint unsigned maxmag, r2, d, p, u;
    longint          qq;
    logic            qneg;
    logic [127:0]    a, prod, fm, limit;
    logic [31:0]     comp [3];
    int              sh, ex, nbits;
    f      = '0;
    maxmag = 0;
    for (int i = 0; i < 3; i++) begin
      diff   = (i == 0) ? longint'(w.charge_x) : (i == 1) ? longint'(w.charge_y)
                                                          : longint'(w.charge_z);
      diff   = diff - longint'(own_pos[i]);
      neg[i] = diff < 0;
      mag[i] = neg[i] ? -diff : diff;
      if (mag[i] > maxmag) maxmag = mag[i];
    end
    if (maxmag == 0) begin
      f.zero_distance = 1'b1;
      return f;
    end
    nbits = 0;
    for (int b = 0; b < 64; b++) if (maxmag[b]) nbits = b + 1;
    sh = nbits - 30;
    for (int i = 0; i < 3; i++) e[i] = (sh >= 0) ? (mag[i] >> sh) : (mag[i] << (-sh));
    r2   = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
    d    = root_floor(r2);
    qq   = longint'(w.charge_q) * longint'(own_q);
    qneg = qq < 0;
    p    = longint'(k_scale) * (qneg ? -qq : qq);
    a    = (128'(p) << 28) / 128'(r2);
    ex   = 2 * sh + 42;
    for (int i = 0; i < 3; i++) begin
      u     = (e[i] << 30) / d;
      prod  = a * 128'(u);
      limit = (neg[i] != qneg) ? 128'h8000_0000 : 128'h7FFF_FFFF;
      fm    = (ex >= 0) ? (prod >> ex) : (prod << (-ex));
      if (fm > limit) begin
        fm          = limit;
        f.saturated = 1'b1;
      end
      comp[i] = (neg[i] != qneg) ? (32'd0 - fm[31:0]) : fm[31:0];
    end
    f.force_x = comp[0];
    f.force_y = comp[1];
    f.force_z = comp[2];
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = force_queue.size();

  // track registers, predict on each input word, check each output word
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      own_pos[0] <= '0;
      own_pos[1] <= '0;
      own_pos[2] <= '0;
      own_q      <= OWN_CHARGE_RST;
      k_scale    <= SCALE_RST;
      errors     = 0;
      force_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_POS_X:  own_pos[0] <= cfg_wdata;
          CFG_POS_Y:  own_pos[1] <= cfg_wdata;
          CFG_POS_Z:  own_pos[2] <= cfg_wdata;
          CFG_CHARGE: own_q      <= cfg_wdata[15:0];
          CFG_SCALE:  k_scale    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) force_queue.push_back(pair_force(in_data));
      if (out_valid && out_ready) begin
        if (force_queue.size() == 0) begin
          report_mismatch("unexpected word", out_data.force_x, '0);
        end else begin
          want = force_queue.pop_front();
          if (out_data.force_x !== want.force_x)
            report_mismatch("force_x", out_data.force_x, want.force_x);
          if (out_data.force_y !== want.force_y)
            report_mismatch("force_y", out_data.force_y, want.force_y);
          if (out_data.force_z !== want.force_z)
            report_mismatch("force_z", out_data.force_z, want.force_z);
          if (out_data.zero_distance !== want.zero_distance)
            report_mismatch("zero_distance", out_data.zero_distance, want.zero_distance);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives charges and register settings into the Coulomb pair force block
// with random gaps and output stalls; the checker judges every word.
// ---------------------------------------------------------------------------
module tb_top;
  import cfp_pkg::*;

  localparam int PIPE_LAT = 70;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  int          pending;
  int          errors;
  int          tx_max;
  int          rx_max;
  int          rx_stall;
  logic        out_fire;
  logic signed [31:0] cur_pos [3];

  cfp_stream_if #(.word_t(in_word_t))  in_ch ();
  cfp_stream_if #(.word_t(out_word_t)) out_ch ();

  coulomb_force_pair dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cfp_force_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: draw a stall after each accepted word
  always @(posedge clk) out_fire <= out_ch.valid && out_ch.ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
      rx_stall     = 0;
    end else begin
      if (out_fire) rx_stall = $urandom_range(0, rx_max);
      if (rx_stall > 0) begin
        out_ch.ready = 1'b0;
        rx_stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    if (idx <= CFG_POS_Z) cur_pos[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold off until the pipe has drained fully
  task automatic drain;
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] q);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = {x, y, z, q};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // coordinate near the element, far away, or on top of it
  function automatic logic [31:0] rand_coord(int axis);
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return cur_pos[axis];
      2:       return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      default: return cur_pos[axis] + (($urandom_range(0, 1) ? -1 : 1) *
                                        int'($urandom >> $urandom_range(1, 31)));
    endcase
  endfunction

  function automatic logic [15:0] rand_charge();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_max = $urandom_range(0, 1) ? 18 : 0;
        rx_max = $urandom_range(0, 1) ? 18 : 0;
      end
      if ($urandom_range(0, 2) == 0)
        send_word($urandom, $urandom, $urandom, 16'($urandom));
      else
        send_word(rand_coord(0), rand_coord(1), rand_coord(2), rand_charge());
    end
  endtask

  initial begin
    cfg_we       = 1'b0;
    cfg_idx      = CFG_POS_X;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    tx_max       = 0;
    rx_max       = 0;
    cur_pos[0]   = '0;
    cur_pos[1]   = '0;
    cur_pos[2]   = '0;
    rst_n        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words against the reset settings
    send_word(32'h0, 32'h0, 32'h0, 16'h0100);              // coincident
    send_word(32'h1, 32'h0, 32'h0, 16'h7FFF);              // one LSB away, clips
    send_word(32'h0, 32'hFFFF_FFFF, 32'h0, 16'h8000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0100);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFF00);
    send_word(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 16'h0000);
    send_word(32'h0001_0000, 32'h0, 32'h0, 16'h0100);
    send_word(32'h0, 32'h0, 32'h0001_0000, 16'hFF00);
    send_word(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080, 16'h7FFF);
    drain();

    // extreme element position and charge, largest scale
    write_reg(CFG_POS_X, 32'h7FFF_FFFF);
    write_reg(CFG_POS_Y, 32'h8000_0000);
    write_reg(CFG_POS_Z, 32'h7FFF_FFFF);
    write_reg(CFG_CHARGE, 32'h0000_8000);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
    send_word(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001);
    send_word(32'h0, 32'h0, 32'h0, 16'hFFFF);
    random_burst(120);
    drain();

    // zero scale
    write_reg(CFG_SCALE, 32'h0);
    send_word(32'h0001_0000, 32'h0, 32'h0, 16'h7FFF);
    random_burst(40);
    drain();

    // zero element charge, odd register index ignored
    write_reg(CFG_SCALE, 32'h0001_0000);
    write_reg(CFG_CHARGE, 32'h0);
    write_reg(cfg_idx_t'(3'd7), 32'hDEAD_BEEF);
    send_word(32'h0001_0000, 32'h0, 32'h0, 16'h7FFF);
    random_burst(40);
    drain();

    // several random settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_POS_X, $urandom);
      write_reg(CFG_POS_Y, (ph == 0) ? 32'h0 : $urandom);
      write_reg(CFG_POS_Z, $urandom >> $urandom_range(0, 31));
      write_reg(CFG_CHARGE, (ph == 1) ? 32'h7FFF : $urandom);
      write_reg(CFG_SCALE, $urandom >> $urandom_range(0, 24));
      random_burst(110);
      drain();
    end

    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
